// ----- rtl/core/swt_pkg.sv -----
package swt_pkg;

	// character codes the splitter reacts to
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0a;
	localparam logic [7:0] CH_CR        = 8'h0d;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;

	// one input item gives at most this many results
	localparam int MAX_RESULTS = 4;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int IDX_W       = $clog2(MAX_RESULTS);

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_WEND = 2'd1,
		KIND_OK   = 2'd2,
		KIND_ERR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		Q_OUT    = 2'd0,
		Q_SINGLE = 2'd1,
		Q_DOUBLE = 2'd2
	} quote_t;

	// error codes carried with a line error
	localparam logic ERR_OPEN_QUOTE  = 1'b0;
	localparam logic ERR_TRAIL_ESC   = 1'b1;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] word_byte;
		logic       error_code;
	} result_t;

	typedef result_t [MAX_RESULTS-1:0] res_list_t;

endpackage

// ----- rtl/core/shell_word_tokenizer_unit.sv -----
// Shell-style word splitter, one command-line byte per input transfer.
// Input channel s_*: s_tdata carries the byte, s_tuser says the byte is
// present (zero lets an empty line close), s_tlast ends the line.
// Output channel m_*: s_tuser-like m_tuser gives the result kind (word
// byte, word end, line accepted, line error), m_tdata holds the word byte
// and the error code, m_tlast marks the final result of one input item.
// An item is registered in the input register, tokenized combinationally
// from it, and its results go to the result register that drives the
// output. Throughput: one input transfer per cycle while each item gives at
// most one result and the receiver does not stall; the single result
// register sends one result per transfer, holding the input until all are sent.
// Items giving no result pass through without using an output cycle.
// When the receiver stalls, the result register holds and the input
// register fills, after which s_tready drops.
// Reset clears both registers and returns the tokenizer to outside any
// quote with no word in progress.
module shell_word_tokenizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic [0:0]  s_tuser,   // [0] has_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] word_byte, [8] error_code, rest zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);
	import swt_pkg::*;

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             has_s1;
	logic             eol_s1;
	logic             out_free;
	logic             advance;
	res_list_t        res;
	logic [CNT_W-1:0] res_cnt;

	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			has_s1  <= s_tuser[0];
			eol_s1  <= s_tlast;
		end
	end

	swt_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.char_byte   (char_s1),
		.has_byte    (has_s1),
		.end_of_line (eol_s1),
		.res         (res),
		.res_cnt     (res_cnt)
	);

	swt_expand u_expand (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res_in   (res),
		.cnt_in   (res_cnt),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- rtl/core/swt_step.sv -----
module swt_step (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic [7:0]                char_byte,
	input  logic                      has_byte,
	input  logic                      end_of_line,
	output swt_pkg::res_list_t        res,
	output logic [swt_pkg::CNT_W-1:0] res_cnt
);
	import swt_pkg::*;

	quote_t quote_q;
	logic   esc_q;
	logic   dq_bs_q;
	logic   word_q;

	quote_t quote_d;
	logic   esc_d;
	logic   dq_bs_d;
	logic   word_d;
	logic   is_space;

	assign is_space = (char_byte == CH_SPACE) || (char_byte == CH_TAB) ||
	                  (char_byte == CH_LF) || (char_byte == CH_CR);

	// tokenizer step: next state and the list of results for one item
	always_comb begin
		res      = '0;
		res_cnt  = '0;
		quote_d  = quote_q;
		esc_d    = esc_q;
		dq_bs_d  = dq_bs_q;
		word_d   = word_q;

		// byte handling
		if (has_byte) begin
			if (esc_d) begin
				esc_d = 1'b0;
				res[res_cnt[IDX_W-1:0]] = '{KIND_BYTE, char_byte, 1'b0};
				res_cnt = res_cnt + 1'b1;
			end else begin
				case (quote_d)
					Q_SINGLE: begin
						if (char_byte == CH_SQUOTE) begin
							quote_d = Q_OUT;
						end else begin
							res[res_cnt[IDX_W-1:0]] = '{KIND_BYTE, char_byte, 1'b0};
							res_cnt = res_cnt + 1'b1;
						end
					end
					Q_DOUBLE: begin
						if (dq_bs_d) begin
							dq_bs_d = 1'b0;
							if (char_byte != CH_DQUOTE && char_byte != CH_BACKSLASH) begin
								res[res_cnt[IDX_W-1:0]] = '{KIND_BYTE, CH_BACKSLASH, 1'b0};
								res_cnt = res_cnt + 1'b1;
							end
							res[res_cnt[IDX_W-1:0]] = '{KIND_BYTE, char_byte, 1'b0};
							res_cnt = res_cnt + 1'b1;
						end else if (char_byte == CH_DQUOTE) begin
							quote_d = Q_OUT;
						end else if (char_byte == CH_BACKSLASH) begin
							dq_bs_d = 1'b1;
						end else begin
							res[res_cnt[IDX_W-1:0]] = '{KIND_BYTE, char_byte, 1'b0};
							res_cnt = res_cnt + 1'b1;
						end
					end
					default: begin
						if (is_space) begin
							if (word_d) begin
								word_d = 1'b0;
								res[res_cnt[IDX_W-1:0]] = '{KIND_WEND, 8'h00, 1'b0};
								res_cnt = res_cnt + 1'b1;
							end
						end else begin
							word_d = 1'b1;
							if (char_byte == CH_SQUOTE) begin
								quote_d = Q_SINGLE;
							end else if (char_byte == CH_DQUOTE) begin
								quote_d = Q_DOUBLE;
							end else if (char_byte == CH_BACKSLASH) begin
								esc_d = 1'b1;
							end else begin
								res[res_cnt[IDX_W-1:0]] = '{KIND_BYTE, char_byte, 1'b0};
								res_cnt = res_cnt + 1'b1;
							end
						end
					end
				endcase
			end
		end

		// line close
		if (end_of_line) begin
			if (esc_d) begin
				res[res_cnt[IDX_W-1:0]] = '{KIND_ERR, 8'h00, ERR_TRAIL_ESC};
				res_cnt = res_cnt + 1'b1;
			end else if (quote_d == Q_SINGLE || quote_d == Q_DOUBLE) begin
				res[res_cnt[IDX_W-1:0]] = '{KIND_ERR, 8'h00, ERR_OPEN_QUOTE};
				res_cnt = res_cnt + 1'b1;
			end else begin
				if (word_d) begin
					res[res_cnt[IDX_W-1:0]] = '{KIND_WEND, 8'h00, 1'b0};
					res_cnt = res_cnt + 1'b1;
				end
				res[res_cnt[IDX_W-1:0]] = '{KIND_OK, 8'h00, 1'b0};
				res_cnt = res_cnt + 1'b1;
			end
			quote_d = Q_OUT;
			esc_d   = 1'b0;
			dq_bs_d = 1'b0;
			word_d  = 1'b0;
		end
	end

	// tokenizer state, updated when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= Q_OUT;
			esc_q   <= 1'b0;
			dq_bs_q <= 1'b0;
			word_q  <= 1'b0;
		end else if (advance) begin
			quote_q <= quote_d;
			esc_q   <= esc_d;
			dq_bs_q <= dq_bs_d;
			word_q  <= word_d;
		end
	end

endmodule

// ----- rtl/core/swt_expand.sv -----
module swt_expand (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  swt_pkg::res_list_t        res_in,
	input  logic [swt_pkg::CNT_W-1:0] cnt_in,
	output logic                      free,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [15:0]               m_tdata,  // [7:0] word_byte, [8] error_code, rest zero
	output logic [1:0]                m_tuser,  // [1:0] kind
	output logic                      m_tlast
);
	import swt_pkg::*;

	res_list_t        res_s2;
	logic [CNT_W-1:0] cnt_s2;
	logic             valid_s2;
	logic [IDX_W-1:0] idx_q;
	logic             at_last;
	result_t          cur;

	assign at_last = ({1'b0, idx_q} == cnt_s2 - 1'b1);
	assign free    = !valid_s2 || (m_tready && at_last);
	assign cur     = res_s2[idx_q];

	// output fields from the held result list
	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, cur.error_code, cur.word_byte};
	assign m_tuser  = cur.kind;
	assign m_tlast  = at_last;

	// control: load a new list or step through the held one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s2 <= (cnt_in != '0);
			idx_q    <= '0;
		end else if (valid_s2 && m_tready) begin
			if (at_last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_in;
			cnt_s2 <= cnt_in;
		end
	end

endmodule
